/* design/dbc_pkg.sv */
// ----------------------------------------------------------------------------
// dbc_pkg: shared types and constants for the debounced button counter
// Word widths, counter limit and the active-low seven-segment decode.
// ----------------------------------------------------------------------------
package dbc_pkg;

   localparam int MAX_BUTTONS     = 8;
   localparam int DEF_NUM_BUTTONS = 8;
   localparam int DEF_DEBOUNCE    = 12;

   localparam int LEVEL_W = 8;
   localparam int CODE_W  = 8;
   localparam int COUNT_W = 10;
   localparam int MASK_W  = 8;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [MASK_W-1:0]  mask_type;
   typedef logic [3:0]         digit_type;

   localparam count_type COUNT_LIMIT = 10'd1023;
   localparam code_type  BLANK_CODE  = 8'hFF;

   // Active-low segment pattern of one decimal digit
   function automatic code_type seg_code(input digit_type digit);
      code_type code;
      case (digit)
         4'd0:    code = 8'b11000000;
         4'd1:    code = 8'b11111001;
         4'd2:    code = 8'b10100100;
         4'd3:    code = 8'b10110000;
         4'd4:    code = 8'b10011001;
         4'd5:    code = 8'b10010010;
         4'd6:    code = 8'b10000010;
         4'd7:    code = 8'b11111000;
         4'd8:    code = 8'b10000000;
         4'd9:    code = 8'b10011000;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

endpackage

/* design/dbc_if.sv */
// ----------------------------------------------------------------------------
// dbc_if: valid/ready channels of the debounced button counter
// Request channel carries the raw button levels, response channel the display.
// ----------------------------------------------------------------------------
interface dbc_req_if import dbc_pkg::*; ();
   logic      valid;
   logic      ready;
   level_type button_levels_n;

   modport source (output valid, output button_levels_n, input ready);
   modport sink   (input valid, input button_levels_n, output ready);
endinterface

interface dbc_rsp_if import dbc_pkg::*; ();
   logic      valid;
   logic      ready;
   code_type  ones_code;
   code_type  tens_code;
   code_type  colon_code;
   code_type  hundreds_code;
   code_type  thousands_code;
   count_type count_value;
   mask_type  press_mask;

   modport source (output valid, output ones_code, output tens_code, output colon_code,
                   output hundreds_code, output thousands_code, output count_value,
                   output press_mask, input ready);
   modport sink   (input valid, input ones_code, input tens_code, input colon_code,
                   input hundreds_code, input thousands_code, input count_value,
                   input press_mask, output ready);
endinterface

/* design/debounced_button_counter_display.sv */
// ----------------------------------------------------------------------------
// Path: an accepted word passes the counter register and the two display registers (three stages).
// Throughput: one word per cycle while rsp ready is high; the counter stage and the two display stages
// (the last one is the output register) form a stall chain fed by the rsp ready.
// Reset: synchronous; clears all button histories, the counter and stage valids.
// ----------------------------------------------------------------------------
// debounced_button_counter_display: top level
// Per-button debounce lanes, press counter merge and seven-segment readout.
// ----------------------------------------------------------------------------
module debounced_button_counter_display import dbc_pkg::*; #(
   parameter int NUM_BUTTONS  = DEF_NUM_BUTTONS,
   parameter int DEBOUNCE_LEN = DEF_DEBOUNCE
) (
   input  logic      clock,
   input  logic      reset,
   dbc_req_if.sink   req_chan,
   dbc_rsp_if.source rsp_chan
);

   logic      req_fire;
   logic      merge_ready;
   logic      merge_valid;
   logic      disp_ready;
   mask_type  lane_press;
   count_type merge_count;
   mask_type  merge_mask;

   assign req_chan.ready = merge_ready;
   assign req_fire       = req_chan.valid && merge_ready;

   // one debounce lane per button; unused bits never flag a press
   for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_lane
      if (i < NUM_BUTTONS) begin : g_used
         dbc_lane #(
            .DEBOUNCE_LEN (DEBOUNCE_LEN)
         ) u_lane (
            .clock    (clock),
            .reset    (reset),
            .shift_en (req_fire),
            .level_n  (req_chan.button_levels_n[i]),
            .press    (lane_press[i])
         );
      end else begin : g_unused
         assign lane_press[i] = 1'b0;
      end
   end

   dbc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_fire),
      .lane_press  (lane_press),
      .dn_ready    (disp_ready),
      .up_ready    (merge_ready),
      .st_valid    (merge_valid),
      .count_value (merge_count),
      .press_mask  (merge_mask)
   );

   dbc_display u_display (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (merge_valid),
      .count_value (merge_count),
      .press_mask  (merge_mask),
      .up_ready    (disp_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

/* design/dbc_lane.sv */
// ----------------------------------------------------------------------------
// dbc_lane: debounce history of one button
// Shifts in the released bit on every accepted word and flags a new press.
// ----------------------------------------------------------------------------
module dbc_lane import dbc_pkg::*; #(
   parameter int DEBOUNCE_LEN = DEF_DEBOUNCE
) (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic level_n,
   output logic press
);

   localparam int HIST_W = DEBOUNCE_LEN + 1;
   localparam logic [HIST_W-1:0] PRESS_PATTERN = {1'b1, {DEBOUNCE_LEN{1'b0}}};

   logic [HIST_W-1:0] history_ff;
   logic [HIST_W-1:0] history_in;

   // one released sample followed by a full run of pressed samples
   assign history_in = {history_ff[DEBOUNCE_LEN-1:0], level_n};
   assign press      = (history_in == PRESS_PATTERN);

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (shift_en) begin
         history_ff <= history_in;
      end
   end

endmodule

/* design/dbc_merge.sv */
// ----------------------------------------------------------------------------
// dbc_merge: press counter
// Adds the lane press flags (bit i weighs 2^i) to the counter and wraps it.
// ----------------------------------------------------------------------------
module dbc_merge import dbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  mask_type  lane_press,
   input  logic      dn_ready,
   output logic      up_ready,
   output logic      st_valid,
   output count_type count_value,
   output mask_type  press_mask
);

   logic                 valid_ff, valid_in;
   count_type            total_ff, total_in;
   mask_type             mask_ff;
   logic [COUNT_W:0]     sum;
   logic [COUNT_W:0]     wrapped;

   // the flag vector is already the weighted sum of the presses
   assign sum      = {1'b0, total_ff} + {{(COUNT_W + 1 - MASK_W){1'b0}}, lane_press};
   assign wrapped  = sum - {1'b0, COUNT_LIMIT};
   assign total_in = sum[COUNT_W] ? wrapped[COUNT_W-1:0] : sum[COUNT_W-1:0];

   // stage holds its word until the display pipe takes it
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = accept ? 1'b1 : (dn_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= lane_press;
      end
   end

   assign st_valid    = valid_ff;
   assign count_value = total_ff;
   assign press_mask  = mask_ff;

endmodule

/* design/dbc_display.sv */
// ----------------------------------------------------------------------------
// dbc_display: binary to decimal seven-segment readout
// Two stages: thousands/hundreds split, then tens/units and segment codes.
// ----------------------------------------------------------------------------
module dbc_display import dbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  count_type count_value,
   input  mask_type  press_mask,
   output logic      up_ready,
   dbc_rsp_if.source rsp_chan
);

   // hundreds and tens weights by digit
   function automatic logic [COUNT_W-1:0] times_100(input digit_type d);
      return COUNT_W'(d) * 10'd100;
   endfunction

   function automatic logic [6:0] times_10(input digit_type d);
      return 7'(d) * 7'd10;
   endfunction

   logic              v2_ff, v3_ff;
   logic              s2_ready, s3_ready;
   logic              s2_load, s3_load;

   count_type         cnt2_ff;
   mask_type          mask2_ff;
   logic              th2_ff;
   digit_type         hun2_ff;
   logic [6:0]        rem2_ff;

   logic              th_in;
   count_type         rem_hi;
   logic [15:0]       hun_prod;
   digit_type         hun_in;
   count_type         rem_lo;

   logic [13:0]       ten_prod;
   digit_type         ten_d;
   logic [6:0]        one_full;

   code_type          ones3_ff, tens3_ff, hun3_ff, th3_ff;
   count_type         cnt3_ff;
   mask_type          mask3_ff;

   // pipe control
   assign s3_ready = !v3_ff || rsp_chan.ready;
   assign s2_ready = !v2_ff || s3_ready;
   assign s2_load  = in_valid && s2_ready;
   assign s3_load  = v2_ff && s3_ready;
   assign up_ready = s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            v2_ff <= in_valid;
         end
         if (s3_ready) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // stage 2: thousands flag, hundreds digit by reciprocal 41/4096
   assign th_in    = (count_value >= 10'd1000);
   assign rem_hi   = th_in ? count_value - 10'd1000 : count_value;
   assign hun_prod = {6'd0, rem_hi} * 16'd41;
   assign hun_in   = hun_prod[15:12];
   assign rem_lo   = rem_hi - times_100(hun_in);

   always_ff @(posedge clock) begin
      if (s2_load) begin
         cnt2_ff  <= count_value;
         mask2_ff <= press_mask;
         th2_ff   <= th_in;
         hun2_ff  <= hun_in;
         rem2_ff  <= rem_lo[6:0];
      end
   end

   // stage 3: tens digit by reciprocal 103/1024, units, codes with blanking
   assign ten_prod = {7'd0, rem2_ff} * 14'd103;
   assign ten_d    = ten_prod[13:10];
   assign one_full = rem2_ff - times_10(ten_d);

   always_ff @(posedge clock) begin
      if (s3_load) begin
         ones3_ff <= seg_code(one_full[3:0]);
         tens3_ff <= (cnt2_ff < 10'd10)  ? BLANK_CODE : seg_code(ten_d);
         hun3_ff  <= (cnt2_ff < 10'd100) ? BLANK_CODE : seg_code(hun2_ff);
         th3_ff   <= th2_ff ? seg_code(4'd1) : BLANK_CODE;
         cnt3_ff  <= cnt2_ff;
         mask3_ff <= mask2_ff;
      end
   end

   assign rsp_chan.valid          = v3_ff;
   assign rsp_chan.ones_code      = ones3_ff;
   assign rsp_chan.tens_code      = tens3_ff;
   assign rsp_chan.colon_code     = BLANK_CODE;
   assign rsp_chan.hundreds_code  = hun3_ff;
   assign rsp_chan.thousands_code = th3_ff;
   assign rsp_chan.count_value    = cnt3_ff;
   assign rsp_chan.press_mask     = mask3_ff;

endmodule
